@@ rtl/icl_pkg.sv @@
// Shared types and constants for the inverter current-limit derivative unit.
// Holds the item structs of both channels and the fixed-point constants.
// No dependencies.
package icl_pkg;

    // Width of every item field, Q3.12.
    localparam int ICL_DW = 16;

    // 0.01 per unit in Q3.12, the floor of the voltage magnitude.
    localparam logic [ICL_DW-1:0] VT_FLOOR = ICL_DW'(41);

    typedef struct packed {
        logic signed [ICL_DW-1:0] volt_real;
        logic signed [ICL_DW-1:0] volt_imag;
        logic signed [ICL_DW-1:0] active_current;
        logic signed [ICL_DW-1:0] reactive_current;
    } t_in_item;

    typedef struct packed {
        logic signed [ICL_DW-1:0] active_rate;
        logic signed [ICL_DW-1:0] reactive_rate;
        logic signed [ICL_DW-1:0] net_current_real;
        logic signed [ICL_DW-1:0] net_current_imag;
    } t_out_item;

endpackage

@@ rtl/inverter_current_limit_derivative_unit.sv @@
// Inverter current-command limiter with current-lag derivative, top level.
// Uses icl_pkg for the item types and icl_iter_pipe for divisions and roots.
//
// Usage
//   Input channel i_valid / o_stall carries one t_in_item: bus voltage and
//   the present active and reactive currents. Output channel o_valid /
//   i_stall carries one t_out_item: the two current derivatives and the
//   currents rotated into the network frame. Every item gives one result.
//   The APB port holds the power references, current limit, priority and
//   time constant at byte addresses 0, 4, 8, 12 and 16; pready is always high.
//   One item is taken every clock cycle while o_stall is low. The depth of
//   the pipeline is set by the bit-per-stage magnitude root (24 stages),
//   command and rotation dividers (40 stages), limit root (15 stages) and
//   rate dividers (25 stages).
//   A stalled result is held in the output register, with one skid entry
//   behind it; o_stall rises only when that entry fills, and then the whole
//   pipeline holds until the receiver takes items again.
//   Reset empties the pipeline and returns the registers to their defaults.
module inverter_current_limit_derivative_unit
    import icl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_in_item    i_data,
    output logic        o_valid,
    input  logic        i_stall,
    output t_out_item   o_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int W      = ICL_DW;
    localparam int PW     = 2 * W;
    localparam int M8_W   = W + 8;
    localparam int NUM_W  = 2 * W + 8;
    localparam int CMD_W  = 24;
    localparam int LIM_W  = 15;
    localparam int RAD_W  = 2 * LIM_W;
    localparam int DF_W   = W + 1;
    localparam int RN_W   = DF_W + 8;
    localparam int MAG_W  = NUM_W;
    localparam int SQ_SW  = 2 * (PW + 1) + 2 * W;
    localparam int NR_SW  = 2 + 2 * W;
    localparam int L_SW   = W + CMD_W + 4 * W;
    localparam int RT_SW  = 1 + 2 * W;

    localparam logic [MAG_W-1:0] POS_LIM = MAG_W'((2 ** (W - 1)) - 1);
    localparam logic [MAG_W-1:0] NEG_LIM = MAG_W'(2 ** (W - 1));

    typedef enum logic [2:0] {
        REG_ACTIVE_REF   = 3'd0,
        REG_REACTIVE_REF = 3'd1,
        REG_CURRENT_LIM  = 3'd2,
        REG_P_PRIORITY   = 3'd3,
        REG_TIME_CONST   = 3'd4
    } t_reg_idx;

    // Saturate a sign and magnitude pair to a signed W-bit value.
    function automatic logic [W-1:0] sat_sm(input logic neg, input logic [MAG_W-1:0] mag);
        logic [W-1:0] res;
        if (!neg) begin
            res = (mag > POS_LIM) ? POS_LIM[W-1:0] : mag[W-1:0];
        end else begin
            res = (mag > NEG_LIM) ? NEG_LIM[W-1:0] : (~mag[W-1:0] + W'(1));
        end
        return res;
    endfunction

    // ---------------------------------------------------------------- config
    logic signed [15:0] r_apref;
    logic signed [15:0] r_rpref;
    logic [LIM_W-1:0]   r_ilim;
    logic               r_pprio;
    logic [15:0]        r_tconst;
    t_reg_idx           reg_idx;

    assign reg_idx = t_reg_idx'(paddr[4:2]);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_apref  <= '0;
            r_rpref  <= '0;
            r_ilim   <= LIM_W'(4096);
            r_pprio  <= 1'b0;
            r_tconst <= 16'd256;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                REG_ACTIVE_REF:   r_apref  <= pwdata[15:0];
                REG_REACTIVE_REF: r_rpref  <= pwdata[15:0];
                REG_CURRENT_LIM:  r_ilim   <= pwdata[LIM_W-1:0];
                REG_P_PRIORITY:   r_pprio  <= pwdata[0];
                REG_TIME_CONST:   r_tconst <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_ACTIVE_REF:   prdata = {{16{r_apref[15]}}, r_apref};
            REG_REACTIVE_REF: prdata = {{16{r_rpref[15]}}, r_rpref};
            REG_CURRENT_LIM:  prdata = {{(32 - LIM_W){1'b0}}, r_ilim};
            REG_P_PRIORITY:   prdata = {31'd0, r_pprio};
            REG_TIME_CONST:   prdata = {16'd0, r_tconst};
            default:          prdata = '0;
        endcase
    end

    // -------------------------------------------------------------- pipeline
    logic en;
    logic r_skid_vld;

    assign en      = !r_skid_vld;
    assign o_stall = r_skid_vld;

    // Stage 0: capture.
    logic     r0_vld;
    t_in_item r0_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
        end else if (en) begin
            r0_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_d <= i_data;
        end
    end

    // Stage 1: squares and rotation products.
    logic              r1_vld;
    logic signed [PW-1:0] r1_vd2, r1_vq2, r1_pd, r1_qq, r1_pq, r1_qd;
    logic signed [W-1:0]  r1_ip, r1_iq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= r0_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_vd2 <= r0_d.volt_real * r0_d.volt_real;
            r1_vq2 <= r0_d.volt_imag * r0_d.volt_imag;
            r1_pd  <= r0_d.active_current * r0_d.volt_real;
            r1_qq  <= r0_d.reactive_current * r0_d.volt_imag;
            r1_pq  <= r0_d.active_current * r0_d.volt_imag;
            r1_qd  <= r0_d.reactive_current * r0_d.volt_real;
            r1_ip  <= r0_d.active_current;
            r1_iq  <= r0_d.reactive_current;
        end
    end

    // Stage 2: sums.
    logic                r2_vld;
    logic [PW-1:0]       r2_sq;
    logic signed [PW:0]  r2_nr, r2_ni;
    logic signed [W-1:0] r2_ip, r2_iq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (en) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_sq <= $unsigned(r1_vd2) + $unsigned(r1_vq2);
            r2_nr <= {r1_pd[PW-1], r1_pd} - {r1_qq[PW-1], r1_qq};
            r2_ni <= {r1_pq[PW-1], r1_pq} + {r1_qd[PW-1], r1_qd};
            r2_ip <= r1_ip;
            r2_iq <= r1_iq;
        end
    end

    // Magnitude with eight extra fraction bits.
    logic              s1_vld;
    logic [M8_W-1:0]   s1_m8;
    logic [SQ_SW-1:0]  s1_side;

    icl_iter_pipe #(
        .IS_SQRT(1), .STEPS(M8_W), .OPW(2 * M8_W), .DVW(1), .SW(SQ_SW)
    ) u_mag_sqrt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (r2_vld),
        .i_op   ({r2_sq, 16'd0}),
        .i_den  (1'b0),
        .i_side ({r2_nr, r2_ni, r2_ip, r2_iq}),
        .o_vld  (s1_vld),
        .o_q    (s1_m8),
        .o_side (s1_side)
    );

    // Stage 3: floored magnitude and sign/magnitude operands.
    logic signed [PW:0]  s1_nr, s1_ni, s1_nr_abs, s1_ni_abs;
    logic signed [W-1:0] s1_ip, s1_iq;
    logic [W-1:0]        s1_vt;
    logic [15:0]         ap_abs, rp_abs;

    assign {s1_nr, s1_ni, s1_ip, s1_iq} = s1_side;
    assign s1_vt     = s1_m8[M8_W-1:8];
    assign s1_nr_abs = s1_nr[PW] ? -s1_nr : s1_nr;
    assign s1_ni_abs = s1_ni[PW] ? -s1_ni : s1_ni;
    assign ap_abs    = r_apref[15] ? (~r_apref + 16'd1) : r_apref;
    assign rp_abs    = r_rpref[15] ? (~r_rpref + 16'd1) : r_rpref;

    logic                r3_vld;
    logic [W-1:0]        r3_den;
    logic [M8_W-1:0]     r3_m8;
    logic                r3_m8z;
    logic [PW-1:0]       r3_nrm, r3_nim;
    logic                r3_nrs, r3_nis;
    logic [15:0]         r3_apm, r3_rpm;
    logic                r3_aps, r3_rps;
    logic signed [W-1:0] r3_ip, r3_iq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (en) begin
            r3_vld <= s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_den <= (s1_vt < VT_FLOOR) ? VT_FLOOR : s1_vt;
            r3_m8  <= s1_m8;
            r3_m8z <= (s1_m8 == '0);
            r3_nrm <= s1_nr_abs[PW-1:0];
            r3_nim <= s1_ni_abs[PW-1:0];
            r3_nrs <= s1_nr[PW];
            r3_nis <= s1_ni[PW];
            r3_apm <= ap_abs;
            r3_rpm <= rp_abs;
            r3_aps <= r_apref[15];
            r3_rps <= r_rpref[15];
            r3_ip  <= s1_ip;
            r3_iq  <= s1_iq;
        end
    end

    // Current commands and rotation quotients, all forty steps long.
    logic              d_vld;
    logic [NUM_W-1:0]  q_ap, q_rp, q_nr, q_ni;
    logic              d_aps, d_rps, d_nis;
    logic [NR_SW-1:0]  d_nr_side;

    icl_iter_pipe #(
        .IS_SQRT(0), .STEPS(NUM_W), .OPW(NUM_W), .DVW(W), .SW(1)
    ) u_div_ap (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(r3_vld),
        .i_op({{(NUM_W - 28){1'b0}}, r3_apm, 12'd0}), .i_den(r3_den),
        .i_side(r3_aps), .o_vld(), .o_q(q_ap), .o_side(d_aps)
    );

    icl_iter_pipe #(
        .IS_SQRT(0), .STEPS(NUM_W), .OPW(NUM_W), .DVW(W), .SW(1)
    ) u_div_rp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(r3_vld),
        .i_op({{(NUM_W - 28){1'b0}}, r3_rpm, 12'd0}), .i_den(r3_den),
        .i_side(r3_rps), .o_vld(), .o_q(q_rp), .o_side(d_rps)
    );

    icl_iter_pipe #(
        .IS_SQRT(0), .STEPS(NUM_W), .OPW(NUM_W), .DVW(M8_W), .SW(NR_SW)
    ) u_div_nr (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(r3_vld),
        .i_op({r3_nrm, 8'd0}), .i_den(r3_m8),
        .i_side({r3_nrs, r3_m8z, r3_ip, r3_iq}),
        .o_vld(d_vld), .o_q(q_nr), .o_side(d_nr_side)
    );

    icl_iter_pipe #(
        .IS_SQRT(0), .STEPS(NUM_W), .OPW(NUM_W), .DVW(M8_W), .SW(1)
    ) u_div_ni (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(r3_vld),
        .i_op({r3_nim, 8'd0}), .i_den(r3_m8),
        .i_side(r3_nis), .o_vld(), .o_q(q_ni), .o_side(d_nis)
    );

    // Stage 4: signed commands; the rotation is final here.
    logic                d_nrs, d_m8z;
    logic signed [W-1:0] d_ip, d_iq;
    logic [CMD_W-1:0]    ap_t, rp_t;

    assign {d_nrs, d_m8z, d_ip, d_iq} = d_nr_side;
    assign ap_t = {1'b0, q_ap[CMD_W-2:0]};
    assign rp_t = {1'b0, q_rp[CMD_W-2:0]};

    logic                    r4_vld;
    logic signed [CMD_W-1:0] r4_ipc, r4_iqc;
    logic signed [W-1:0]     r4_netr, r4_neti, r4_ip, r4_iq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (en) begin
            r4_vld <= d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_ipc  <= d_aps ? -ap_t : ap_t;
            r4_iqc  <= d_rps ? -rp_t : rp_t;
            // With zero voltage the rotation is the identity.
            r4_netr <= d_m8z ? d_ip : sat_sm(d_nrs, q_nr);
            r4_neti <= d_m8z ? d_iq : sat_sm(d_nis, q_ni);
            r4_ip   <= d_ip;
            r4_iq   <= d_iq;
        end
    end

    // Stage 5: clamp the command that has priority to the current limit.
    logic signed [CMD_W-1:0] imax_c, pri_raw, pri_c;

    assign imax_c  = {{(CMD_W - LIM_W){1'b0}}, r_ilim};
    assign pri_raw = r_pprio ? r4_ipc : r4_iqc;
    assign pri_c   = (pri_raw > imax_c) ? imax_c :
                     (pri_raw < -imax_c) ? -imax_c : pri_raw;

    logic                    r5_vld;
    logic signed [W-1:0]     r5_pri;
    logic signed [CMD_W-1:0] r5_sec;
    logic signed [W-1:0]     r5_netr, r5_neti, r5_ip, r5_iq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else if (en) begin
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_pri  <= pri_c[W-1:0];
            r5_sec  <= r_pprio ? r4_iqc : r4_ipc;
            r5_netr <= r4_netr;
            r5_neti <= r4_neti;
            r5_ip   <= r4_ip;
            r5_iq   <= r4_iq;
        end
    end

    // Stage 6: squares for the remaining headroom.
    logic signed [PW-1:0] pri_sq;
    assign pri_sq = r5_pri * r5_pri;

    logic                    r6_vld;
    logic [RAD_W-1:0]        r6_imax2, r6_pri2;
    logic signed [W-1:0]     r6_pri;
    logic signed [CMD_W-1:0] r6_sec;
    logic signed [W-1:0]     r6_netr, r6_neti, r6_ip, r6_iq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else if (en) begin
            r6_vld <= r5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_imax2 <= r_ilim * r_ilim;
            r6_pri2  <= pri_sq[RAD_W-1:0];
            r6_pri   <= r5_pri;
            r6_sec   <= r5_sec;
            r6_netr  <= r5_netr;
            r6_neti  <= r5_neti;
            r6_ip    <= r5_ip;
            r6_iq    <= r5_iq;
        end
    end

    // Stage 7: radicand of the limit on the other command.
    logic                    r7_vld;
    logic [RAD_W-1:0]        r7_rad;
    logic [L_SW-1:0]         r7_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_vld <= 1'b0;
        end else if (en) begin
            r7_vld <= r6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_rad  <= r6_imax2 - r6_pri2;
            r7_side <= {r6_pri, r6_sec, r6_netr, r6_neti, r6_ip, r6_iq};
        end
    end

    logic             l_vld;
    logic [LIM_W-1:0] l_lim;
    logic [L_SW-1:0]  l_side;

    icl_iter_pipe #(
        .IS_SQRT(1), .STEPS(LIM_W), .OPW(RAD_W), .DVW(1), .SW(L_SW)
    ) u_lim_sqrt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (r7_vld),
        .i_op   (r7_rad),
        .i_den  (1'b0),
        .i_side (r7_side),
        .o_vld  (l_vld),
        .o_q    (l_lim),
        .o_side (l_side)
    );

    // Stage 8: clamp the other command to the headroom.
    logic signed [W-1:0]     l_pri, l_netr, l_neti, l_ip, l_iq;
    logic signed [CMD_W-1:0] l_sec, lim_s, sec_c;

    assign {l_pri, l_sec, l_netr, l_neti, l_ip, l_iq} = l_side;
    assign lim_s = {{(CMD_W - LIM_W){1'b0}}, l_lim};

    always_comb begin
        if (r_pprio) begin
            sec_c = (l_sec > lim_s) ? lim_s : (l_sec < -lim_s) ? -lim_s : l_sec;
        end else begin
            // Active current is never negative under reactive priority.
            sec_c = (l_sec > lim_s) ? lim_s : (l_sec < 0) ? '0 : l_sec;
        end
    end

    logic                r8_vld;
    logic signed [W-1:0] r8_ipc, r8_iqc, r8_netr, r8_neti, r8_ip, r8_iq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_vld <= 1'b0;
        end else if (en) begin
            r8_vld <= l_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r8_ipc  <= r_pprio ? l_pri : sec_c[W-1:0];
            r8_iqc  <= r_pprio ? sec_c[W-1:0] : l_pri;
            r8_netr <= l_netr;
            r8_neti <= l_neti;
            r8_ip   <= l_ip;
            r8_iq   <= l_iq;
        end
    end

    // Stage 9: active command minus state and negated sum of reactive command and state, as sign and magnitude.
    logic signed [DF_W-1:0] da, dr, da_abs, dr_abs;

    assign da     = {r8_ipc[W-1], r8_ipc} - {r8_ip[W-1], r8_ip};
    assign dr     = -({r8_iqc[W-1], r8_iqc} + {r8_iq[W-1], r8_iq});
    assign da_abs = da[DF_W-1] ? -da : da;
    assign dr_abs = dr[DF_W-1] ? -dr : dr;

    logic                r9_vld;
    logic [DF_W-1:0]     r9_dam, r9_drm;
    logic                r9_das, r9_drs;
    logic [15:0]         r9_tg;
    logic signed [W-1:0] r9_netr, r9_neti;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r9_vld <= 1'b0;
        end else if (en) begin
            r9_vld <= r8_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r9_dam  <= da_abs;
            r9_drm  <= dr_abs;
            r9_das  <= da[DF_W-1];
            r9_drs  <= dr[DF_W-1];
            r9_tg   <= (r_tconst == 16'd0) ? 16'd1 : r_tconst;
            r9_netr <= r8_netr;
            r9_neti <= r8_neti;
        end
    end

    logic             t_vld;
    logic [RN_W-1:0]  q_ra, q_rr;
    logic [RT_SW-1:0] t_side;
    logic             t_drs;

    icl_iter_pipe #(
        .IS_SQRT(0), .STEPS(RN_W), .OPW(RN_W), .DVW(16), .SW(RT_SW)
    ) u_div_ra (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(r9_vld),
        .i_op({r9_dam, 8'd0}), .i_den(r9_tg),
        .i_side({r9_das, r9_netr, r9_neti}),
        .o_vld(t_vld), .o_q(q_ra), .o_side(t_side)
    );

    icl_iter_pipe #(
        .IS_SQRT(0), .STEPS(RN_W), .OPW(RN_W), .DVW(16), .SW(1)
    ) u_div_rr (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(r9_vld),
        .i_op({r9_drm, 8'd0}), .i_den(r9_tg),
        .i_side(r9_drs), .o_vld(), .o_q(q_rr), .o_side(t_drs)
    );

    // Stage 10: saturated result.
    logic                t_das;
    logic signed [W-1:0] t_netr, t_neti;

    assign {t_das, t_netr, t_neti} = t_side;

    logic      r10_vld;
    t_out_item r10_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r10_vld <= 1'b0;
        end else if (en) begin
            r10_vld <= t_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r10_d.active_rate      <= sat_sm(t_das, MAG_W'(q_ra));
            r10_d.reactive_rate    <= sat_sm(t_drs, MAG_W'(q_rr));
            r10_d.net_current_real <= t_netr;
            r10_d.net_current_imag <= t_neti;
        end
    end

    // Output register with one skid entry. The last stage hands over its item
    // in every cycle in which the pipeline advances.
    logic      r_out_vld;
    t_out_item r_out;
    t_out_item r_skid;
    logic      out_free;

    assign out_free = !r_out_vld || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (out_free) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end
        end else if (out_free) begin
            r_out_vld <= r10_vld;
        end else if (r10_vld) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (out_free) begin
                r_out <= r_skid;
            end
        end else if (out_free) begin
            r_out <= r10_d;
        end else begin
            r_skid <= r10_d;
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

`ifndef NO_ASSERTIONS
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid entry holds an item while the output register is empty");

    a_skid_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |=> $stable(r10_vld) && $stable(r10_d))
        else $error("last stage moved while the skid entry was full");

    a_skid_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_vld && i_stall) |=> r_skid_vld)
        else $error("skid item dropped while the receiver stalled");
`endif

endmodule

@@ rtl/icl_iter_pipe.sv @@
// Pipelined restoring unit: one quotient or root bit per register stage.
// Used for the unsigned divisions and square roots of the current-limit unit.
// Self-contained; no package dependency.
module icl_iter_pipe #(
    parameter int IS_SQRT = 0,
    parameter int STEPS   = 8,
    parameter int OPW     = 8,
    parameter int DVW     = 8,
    parameter int SW      = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  logic [OPW-1:0]   i_op,
    input  logic [DVW-1:0]   i_den,
    input  logic [SW-1:0]    i_side,
    output logic             o_vld,
    output logic [STEPS-1:0] o_q,
    output logic [SW-1:0]    o_side
);

    localparam int RMW = (IS_SQRT != 0) ? STEPS + 2 : DVW + 1;
    localparam int SH  = (IS_SQRT != 0) ? 2 : 1;

    logic [STEPS-1:0] r_vld;
    logic [RMW-1:0]   r_rem  [STEPS];
    logic [STEPS-1:0] r_q    [STEPS];
    logic [OPW-1:0]   r_op   [STEPS];
    logic [DVW-1:0]   r_den  [STEPS];
    logic [SW-1:0]    r_side [STEPS];

    genvar k;
    for (k = 0; k < STEPS; k++) begin : g_step
        logic             prev_vld;
        logic [RMW-1:0]   prev_rem;
        logic [STEPS-1:0] prev_q;
        logic [OPW-1:0]   prev_op;
        logic [DVW-1:0]   prev_den;
        logic [SW-1:0]    prev_side;
        logic [RMW-1:0]   cand;
        logic [RMW-1:0]   trial;
        logic [RMW-1:0]   n_rem;
        logic             n_bit;

        if (k == 0) begin : g_first
            assign prev_vld  = i_vld;
            assign prev_rem  = '0;
            assign prev_q    = '0;
            assign prev_op   = i_op;
            assign prev_den  = i_den;
            assign prev_side = i_side;
        end else begin : g_next
            assign prev_vld  = r_vld[k-1];
            assign prev_rem  = r_rem[k-1];
            assign prev_q    = r_q[k-1];
            assign prev_op   = r_op[k-1];
            assign prev_den  = r_den[k-1];
            assign prev_side = r_side[k-1];
        end

        if (IS_SQRT != 0) begin : g_sqrt
            // Bring down two radicand bits and try (4 * root + 1).
            assign cand  = {prev_rem[RMW-3:0], prev_op[OPW-1 -: 2]};
            assign trial = {prev_q, 2'b01};
        end else begin : g_div
            assign cand  = {prev_rem[RMW-2:0], prev_op[OPW-1]};
            assign trial = {1'b0, prev_den};
        end

        assign n_bit = (cand >= trial);
        assign n_rem = n_bit ? (cand - trial) : cand;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= prev_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_q[k]    <= {prev_q[STEPS-2:0], n_bit};
                r_op[k]   <= prev_op << SH;
                r_den[k]  <= prev_den;
                r_side[k] <= prev_side;
            end
        end
    end

    assign o_vld  = r_vld[STEPS-1];
    assign o_q    = r_q[STEPS-1];
    assign o_side = r_side[STEPS-1];

endmodule

@@ bench/inverter_current_limit_derivative_unit_test.sv @@
// Testbench for the inverter current-limit derivative unit.
// Predicts every result from the current limiter arithmetic and compares it field by field.
// Depends on icl_pkg and inverter_current_limit_derivative_unit.
module inverter_current_limit_derivative_unit_test;
    import icl_pkg::*;

    localparam int REG_PREF = 0;
    localparam int REG_QREF = 1;
    localparam int REG_ILIM = 2;
    localparam int REG_PRIO = 3;
    localparam int REG_TG   = 4;
    localparam int LATENCY  = 115;
    localparam longint CYCLE_LIMIT = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    t_in_item    i_data;
    logic        o_valid;
    logic        i_stall;
    t_out_item   o_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    longint p_ref;
    longint q_ref;
    longint i_lim;
    bit     p_first;
    longint tg_reg;

    t_out_item expected_rates[$];
    int        mismatches;
    longint    cycles;
    bit        rx_busy;

    inverter_current_limit_derivative_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_data(i_data),
        .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic longint int_root(longint x);
        longint r;
        longint b;
        r = 0;
        b = longint'(1) << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint lim_range(longint v, longint lo, longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic logic [ICL_DW-1:0] sat16(longint v);
        return ICL_DW'(lim_range(v, -32768, 32767));
    endfunction

    function automatic t_out_item predict_rates(t_in_item it);
        longint vd, vq, ip, iq, m8, vt, den, tg, ipc, iqc, lim, netr, neti;
        t_out_item r;
        vd = longint'(it.volt_real);
        vq = longint'(it.volt_imag);
        ip = longint'(it.active_current);
        iq = longint'(it.reactive_current);
        m8 = int_root((vd * vd + vq * vq) << 16);
        vt = m8 >> 8;
        den = (vt < 41) ? 41 : vt;
        tg = (tg_reg == 0) ? 1 : tg_reg;
        ipc = (p_ref * 4096) / den;
        iqc = (q_ref * 4096) / den;
        if (!p_first) begin
            iqc = lim_range(iqc, -i_lim, i_lim);
            lim = int_root(i_lim * i_lim - iqc * iqc);
            ipc = lim_range(ipc, 0, lim);
        end else begin
            ipc = lim_range(ipc, -i_lim, i_lim);
            lim = int_root(i_lim * i_lim - ipc * ipc);
            iqc = lim_range(iqc, -lim, lim);
        end
        if (m8 == 0) begin
            netr = ip;
            neti = iq;
        end else begin
            netr = ((ip * vd - iq * vq) * 256) / m8;
            neti = ((ip * vq + iq * vd) * 256) / m8;
        end
        r.active_rate      = sat16(((ipc - ip) * 256) / tg);
        r.reactive_rate    = sat16((-(iqc + iq) * 256) / tg);
        r.net_current_real = sat16(netr);
        r.net_current_imag = sat16(neti);
        return r;
    endfunction

    task automatic write_reg(int idx, logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 5'(4 * idx);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_PREF: p_ref   = longint'($signed(value[15:0]));
            REG_QREF: q_ref   = longint'($signed(value[15:0]));
            REG_ILIM: i_lim   = longint'(value[14:0]);
            REG_PRIO: p_first = value[0];
            REG_TG:   tg_reg  = longint'(value[15:0]);
            default: ;
        endcase
    endtask

    task automatic set_all(logic [15:0] p, logic [15:0] q, logic [14:0] lim,
                           bit prio, logic [15:0] tg);
        write_reg(REG_PREF, {16'h0, p});
        write_reg(REG_QREF, {16'h0, q});
        write_reg(REG_ILIM, {17'h0, lim});
        write_reg(REG_PRIO, {31'h0, prio});
        write_reg(REG_TG, {16'h0, tg});
    endtask

    // Sends one item, holding it until accepted, after a random gap. It is
    // called at a rising edge and returns at the edge that accepts the item,
    // so that a gap of zero gives back-to-back items.
    task automatic send_item(t_in_item it);
        int gap;
        gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3));
        if (rx_busy) gap = 0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= it;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        expected_rates.push_back(predict_rates(it));
    endtask

    task automatic drain;
        i_valid <= 1'b0;
        while (expected_rates.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_field();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'(int'($urandom_range(0, 100)) - 50);
            3: return 16'(int'($urandom_range(0, 8192)) - 4096);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_in_item rand_item();
        t_in_item it;
        it.volt_real        = rand_field();
        it.volt_imag        = rand_field();
        it.active_current   = rand_field();
        it.reactive_current = rand_field();
        if ($urandom_range(0, 9) == 0) begin
            it.volt_real = '0;
            it.volt_imag = '0;
        end
        return it;
    endfunction

    task automatic test_directed;
        t_in_item it;
        logic [15:0] edges [5];
        edges = '{16'h0000, 16'h8000, 16'h7fff, 16'h0001, 16'hffff};
        set_all(16'd4096, 16'd2048, 15'd4096, 1'b0, 16'd256);
        for (int k = 0; k < 5; k++) begin
            it = '{edges[k], edges[4-k], edges[(k+2)%5], edges[(k+1)%5]};
            send_item(it);
        end
        // Zero voltage gives the identity rotation.
        send_item('{16'h0, 16'h0, 16'h1234, 16'hedcb});
        send_item('{16'd41, 16'd0, 16'd0, 16'd0});
        send_item('{16'd4096, 16'd0, 16'd100, 16'hff00});
        drain();
        // Active priority, zero time constant, command well beyond the limit.
        set_all(16'h7fff, 16'h8000, 15'd100, 1'b1, 16'd0);
        for (int k = 0; k < 5; k++) send_item('{edges[k], edges[k], edges[k], edges[k]});
        send_item('{16'h0, 16'h0, 16'h0, 16'h0});
        drain();
        set_all(16'h8000, 16'h7fff, 15'h7fff, 1'b0, 16'hffff);
        for (int k = 0; k < 5; k++) send_item('{edges[k], 16'd3000, edges[k], edges[4-k]});
        send_item('{16'h0, 16'h0, 16'h7fff, 16'h8000});
        drain();
        set_all(16'd1000, 16'hfc00, 15'd0, 1'b1, 16'd1);
        send_item('{16'd4096, 16'd4096, 16'd10, 16'd20});
        drain();
    endtask

    task automatic test_random;
        for (int ph = 0; ph < 12; ph++) begin
            set_all(rand_field(), rand_field(),
                    ($urandom_range(0, 3) == 0) ? 15'h7fff : 15'($urandom_range(0, 8192)),
                    1'($urandom), ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 2))
                                                             : 16'($urandom));
            for (int n = 0; n < 118; n++) send_item(rand_item());
            drain();
        end
    endtask

    // Receiver stall, with calm stretches where it never stalls.
    initial begin
        int hold;
        i_stall = 1'b0;
        rx_busy = 1'b0;
        forever begin
            @(posedge i_clk);
            if ($urandom_range(0, 199) == 0) rx_busy = !rx_busy;
            hold = rx_busy ? 0 : $urandom_range(0, 3);
            if (hold != 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_out_item exp_item;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_rates.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_data);
                mismatches++;
            end else begin
                exp_item = expected_rates.pop_front();
                if (o_data.active_rate !== exp_item.active_rate) begin
                    $display("%0t: active_rate expected %0d actual %0d", $time,
                             exp_item.active_rate, o_data.active_rate);
                    mismatches++;
                end
                if (o_data.reactive_rate !== exp_item.reactive_rate) begin
                    $display("%0t: reactive_rate expected %0d actual %0d", $time,
                             exp_item.reactive_rate, o_data.reactive_rate);
                    mismatches++;
                end
                if (o_data.net_current_real !== exp_item.net_current_real) begin
                    $display("%0t: net_current_real expected %0d actual %0d", $time,
                             exp_item.net_current_real, o_data.net_current_real);
                    mismatches++;
                end
                if (o_data.net_current_imag !== exp_item.net_current_imag) begin
                    $display("%0t: net_current_imag expected %0d actual %0d", $time,
                             exp_item.net_current_imag, o_data.net_current_imag);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        mismatches = 0;
        cycles = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        p_ref = 0;
        q_ref = 0;
        i_lim = 4096;
        p_first = 1'b0;
        tg_reg = 256;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // Reset defaults are checked before any register write.
        send_item('{16'd4096, 16'd0, 16'd0, 16'd0});
        drain();
        test_directed();
        test_random();
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

@@ files.f @@
rtl/icl_pkg.sv
rtl/icl_iter_pipe.sv
rtl/inverter_current_limit_derivative_unit.sv
bench/inverter_current_limit_derivative_unit_test.sv
